FILE: rtl/hkd_pkg.sv
// Package for the HID keyboard report decoder: result kinds, report classes,
// the queued command type and the US-layout key code to ASCII translation.
// Has no dependencies.
`timescale 1ns / 1ps

package hkd_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned NumKeys    = 6;

  localparam logic [6:0] LenKeyboard = 7'd8;
  localparam logic [6:0] LenMedia    = 7'd3;

  localparam logic [7:0] ShiftMask    = 8'h22;
  localparam logic [7:0] CodeRollover = 8'h01;
  localparam logic [7:0] CodeA        = 8'h04;
  localparam logic [7:0] CodeZ        = 8'h1D;
  localparam logic [7:0] CodeFirstSym = 8'h1E;
  localparam logic [7:0] CodeLastSym  = 8'h38;

  localparam logic [6:0] AsciiUpperA = 7'h41;
  localparam logic [6:0] AsciiLowerA = 7'h61;

  typedef enum logic [2:0] {
    KindChar      = 3'd0,
    KindRollover  = 3'd1,
    KindUnmapped  = 3'd2,
    KindEnd       = 3'd3,
    KindMedia     = 3'd4,
    KindUnhandled = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    RptKeyboard  = 2'd0,
    RptMedia     = 2'd1,
    RptUnhandled = 2'd2
  } rpt_e;

  // One classified report. For media reports mod carries byte 0, b1 byte 1
  // and keys[0] byte 2.
  typedef struct packed {
    rpt_e                      rpt;
    logic                      shift;
    logic [NumKeys-1:0]        key_mask;
    logic [7:0]                mod;
    logic [7:0]                b1;
    logic [NumKeys-1:0][7:0]   keys;
  } cmd_t;

  localparam logic [6:0] SymPlain [27] = '{
    7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
    7'h0A, 7'h00, 7'h08, 7'h09, 7'h20, 7'h2D, 7'h3D, 7'h5B, 7'h5D, 7'h5C,
    7'h00, 7'h3B, 7'h27, 7'h60, 7'h2C, 7'h2E, 7'h2F
  };

  localparam logic [6:0] SymShift [27] = '{
    7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
    7'h0A, 7'h00, 7'h08, 7'h09, 7'h20, 7'h5F, 7'h2B, 7'h7B, 7'h7D, 7'h7C,
    7'h00, 7'h3A, 7'h22, 7'h7E, 7'h3C, 7'h3E, 7'h3F
  };

  // Returns zero for codes without a mapping.
  function automatic logic [6:0] to_ascii(input logic [7:0] code, input logic shift);
    logic [7:0] off;
    logic [7:0] sym_off;
    logic [6:0] ch;
    off     = code - CodeA;
    sym_off = code - CodeFirstSym;
    ch      = '0;
    if (code >= CodeA && code <= CodeZ) begin
      ch = (shift ? AsciiUpperA : AsciiLowerA) + off[6:0];
    end else if (code >= CodeFirstSym && code <= CodeLastSym) begin
      ch = shift ? SymShift[sym_off[4:0]] : SymPlain[sym_off[4:0]];
    end
    return ch;
  endfunction

endpackage

FILE: rtl/hkd_front.sv
// Front end of the HID keyboard report decoder: takes a report transaction and
// classifies it into a queued command. Depends on hkd_pkg.
`timescale 1ns / 1ps

module hkd_front (
  input  logic                 start,
  input  logic                 full_i,
  input  logic [6:0]           report_length_i,
  input  logic [7:0]           byte_0_i,
  input  logic [7:0]           byte_1_i,
  input  logic [7:0]           byte_2_i,
  input  logic [7:0]           byte_3_i,
  input  logic [7:0]           byte_4_i,
  input  logic [7:0]           byte_5_i,
  input  logic [7:0]           byte_6_i,
  input  logic [7:0]           byte_7_i,
  output logic                 busy,
  output logic                 push_o,
  output hkd_pkg::cmd_t        cmd_o
);

  logic [hkd_pkg::NumKeys-1:0][7:0] keys;
  logic [hkd_pkg::NumKeys-1:0]      nonzero;
  logic                             is_kbd;

  assign keys    = {byte_7_i, byte_6_i, byte_5_i, byte_4_i, byte_3_i, byte_2_i};
  assign is_kbd  = (report_length_i == hkd_pkg::LenKeyboard);
  assign busy    = full_i;
  assign push_o  = start && !full_i;

  always_comb begin
    for (int i = 0; i < hkd_pkg::NumKeys; i++) begin
      nonzero[i] = (keys[i] != 8'h00);
    end
  end

  always_comb begin
    cmd_o.shift    = (byte_0_i & hkd_pkg::ShiftMask) != 8'h00;
    cmd_o.key_mask = is_kbd ? nonzero : '0;
    cmd_o.mod      = byte_0_i;
    cmd_o.b1       = byte_1_i;
    cmd_o.keys     = keys;
    if (is_kbd) begin
      cmd_o.rpt = hkd_pkg::RptKeyboard;
    end else if (report_length_i == hkd_pkg::LenMedia) begin
      cmd_o.rpt = hkd_pkg::RptMedia;
    end else begin
      cmd_o.rpt = hkd_pkg::RptUnhandled;
    end
  end

endmodule

FILE: rtl/hkd_queue.sv
// Short command queue between the front and back ends of the HID keyboard
// report decoder. Depends on hkd_pkg.
`timescale 1ns / 1ps

module hkd_queue #(
  parameter int unsigned Depth = hkd_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hkd_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output hkd_pkg::cmd_t data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  hkd_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/hkd_back.sv
// Back end of the HID keyboard report decoder: takes commands from the queue
// and issues one result per cycle while it holds a command. Depends on hkd_pkg.
`timescale 1ns / 1ps

module hkd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  hkd_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          strobe_o,
  output logic [2:0]    kind_o,
  output logic [6:0]    character_o,
  output logic [7:0]    key_code_o,
  output logic [7:0]    modifiers_o,
  output logic [7:0]    media_first_o,
  output logic [7:0]    media_second_o,
  output logic [7:0]    media_third_o,
  output logic          last_o
);

  localparam int unsigned SelW = $clog2(hkd_pkg::NumKeys);

  logic                        cur_valid_q, cur_valid_d;
  hkd_pkg::cmd_t               cur_q, cur_d;
  logic [hkd_pkg::NumKeys-1:0] mask_q, mask_d, sel_onehot;
  logic [SelW-1:0]             sel;
  logic                        has_key, is_final;
  logic [7:0]                  code;
  logic [6:0]                  ch;

  hkd_pkg::kind_e kind_d;
  logic [6:0]     character_d;
  logic [7:0]     key_code_d, modifiers_d, media_first_d, media_second_d, media_third_d;
  logic           last_d;

  always_comb begin
    sel        = '0;
    sel_onehot = '0;
    for (int i = hkd_pkg::NumKeys - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel        = SelW'(i);
        sel_onehot = '0;
        sel_onehot[i] = 1'b1;
      end
    end
  end

  assign has_key  = cur_valid_q && (mask_q != '0);
  assign is_final = cur_valid_q && (mask_q == '0);
  assign pop_o    = !cur_valid_q || is_final;
  assign code     = cur_q.keys[sel];
  assign ch       = hkd_pkg::to_ascii(code, cur_q.shift);

  always_comb begin
    cur_valid_d = cur_valid_q;
    cur_d       = cur_q;
    mask_d      = mask_q;
    if (pop_o) begin
      cur_valid_d = valid_i;
      cur_d       = cmd_i;
      mask_d      = valid_i ? cmd_i.key_mask : '0;
    end else if (has_key) begin
      mask_d = mask_q & ~sel_onehot;
    end
  end

  always_comb begin
    kind_d         = hkd_pkg::KindUnhandled;
    character_d    = '0;
    key_code_d     = '0;
    modifiers_d    = '0;
    media_first_d  = '0;
    media_second_d = '0;
    media_third_d  = '0;
    last_d         = 1'b0;
    if (has_key) begin
      key_code_d = code;
      if (code == hkd_pkg::CodeRollover) begin
        kind_d = hkd_pkg::KindRollover;
      end else if (ch != 7'h00) begin
        kind_d      = hkd_pkg::KindChar;
        character_d = ch;
      end else begin
        kind_d = hkd_pkg::KindUnmapped;
      end
    end else begin
      last_d = 1'b1;
      unique case (cur_q.rpt)
        hkd_pkg::RptKeyboard: begin
          kind_d      = hkd_pkg::KindEnd;
          modifiers_d = cur_q.mod;
        end
        hkd_pkg::RptMedia: begin
          kind_d         = hkd_pkg::KindMedia;
          media_first_d  = cur_q.mod;
          media_second_d = cur_q.b1;
          media_third_d  = cur_q.keys[0];
        end
        default: begin
          kind_d = hkd_pkg::KindUnhandled;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      mask_q      <= '0;
      strobe_o    <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      mask_q      <= mask_d;
      strobe_o    <= cur_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q          <= cur_d;
    kind_o         <= kind_d;
    character_o    <= character_d;
    key_code_o     <= key_code_d;
    modifiers_o    <= modifiers_d;
    media_first_o  <= media_first_d;
    media_second_o <= media_second_d;
    media_third_o  <= media_third_d;
    last_o         <= last_d;
  end

  // The results of one report leave in consecutive cycles.
  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> strobe_o)
    else $error("report results not contiguous");

  // Only key results may come before the last result of a report.
  a_key_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |-> (kind_o == hkd_pkg::KindChar ||
                             kind_o == hkd_pkg::KindRollover ||
                             kind_o == hkd_pkg::KindUnmapped))
    else $error("non-key result without last");

  // Key slots are only pending for keyboard reports.
  a_mask_kbd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q && cur_q.rpt != hkd_pkg::RptKeyboard |-> mask_q == '0)
    else $error("pending key slots on a non-keyboard report");

  // A pending key slot always holds a nonzero code.
  a_key_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    has_key |-> code != 8'h00)
    else $error("empty key slot selected");

endmodule

FILE: rtl/hid_keyboard_report_decoder_unit.sv
// Top level of the HID keyboard report decoder: front end, command queue and
// back end. Depends on hkd_pkg, hkd_front, hkd_queue and hkd_back.
//
//   Channel   Handshake            Ports
//   report    start / busy         report_length_i, byte_0_i .. byte_7_i
//   result    strobe_o (1 cycle)   kind_o, character_o, key_code_o, modifiers_o,
//                                  media_first_o .. media_third_o, last_o
//
// A report is taken when start is high and busy is low. The back end issues one
// result per cycle while it holds a command: one per nonzero key slot plus an end
// result (1 to 7) for a keyboard report, one for a media or unhandled report. A
// report passes the queue and back-end command register before its first result.
// busy is high only while the queue is full. Reset empties it and the back end.
`timescale 1ns / 1ps

module hid_keyboard_report_decoder_unit #(
  parameter int unsigned QueueDepth = hkd_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [6:0] report_length_i,
  input  logic [7:0] byte_0_i,
  input  logic [7:0] byte_1_i,
  input  logic [7:0] byte_2_i,
  input  logic [7:0] byte_3_i,
  input  logic [7:0] byte_4_i,
  input  logic [7:0] byte_5_i,
  input  logic [7:0] byte_6_i,
  input  logic [7:0] byte_7_i,
  output logic       strobe_o,
  output logic [2:0] kind_o,
  output logic [6:0] character_o,
  output logic [7:0] key_code_o,
  output logic [7:0] modifiers_o,
  output logic [7:0] media_first_o,
  output logic [7:0] media_second_o,
  output logic [7:0] media_third_o,
  output logic       last_o
);

  hkd_pkg::cmd_t push_cmd, pop_cmd;
  logic          push, full, pop, pop_valid;

  hkd_front u_front (
    .start           (start),
    .full_i          (full),
    .report_length_i (report_length_i),
    .byte_0_i        (byte_0_i),
    .byte_1_i        (byte_1_i),
    .byte_2_i        (byte_2_i),
    .byte_3_i        (byte_3_i),
    .byte_4_i        (byte_4_i),
    .byte_5_i        (byte_5_i),
    .byte_6_i        (byte_6_i),
    .byte_7_i        (byte_7_i),
    .busy            (busy),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  hkd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (pop_valid),
    .data_o  (pop_cmd)
  );

  hkd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (pop_valid),
    .cmd_i          (pop_cmd),
    .pop_o          (pop),
    .strobe_o       (strobe_o),
    .kind_o         (kind_o),
    .character_o    (character_o),
    .key_code_o     (key_code_o),
    .modifiers_o    (modifiers_o),
    .media_first_o  (media_first_o),
    .media_second_o (media_second_o),
    .media_third_o  (media_third_o),
    .last_o         (last_o)
  );

endmodule
